/* design/gijr_pkg.sv */
// ----------------------------------------------------------------------------
// gijr_pkg: shared types and constants
// Codes, widths and control records of the Jacobi reconstruction unit.
// ----------------------------------------------------------------------------
package gijr_pkg;

  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;
  localparam int DefChannels  = 3;

  localparam int ActW   = 2;
  localparam int IdxW   = 14;
  localparam int DataW  = 32;
  localparam int AlphaW = 16;
  localparam int IterW  = 12;
  localparam int DimW   = 7;
  localparam int CfgIdxW = 2;

  localparam int AsqW  = 24;
  localparam int ProdW = DataW + AsqW + 1;
  localparam int NumW  = 64;
  localparam int DenW  = 26;
  localparam int UnitG = 16;
  localparam int UnitR = 17;

  localparam logic [AlphaW-1:0] AlphaRst = AlphaW'(819);
  localparam logic [IterW-1:0]  IterRst  = IterW'(200);
  localparam logic [DimW-1:0]   DimRst   = DimW'(64);

  localparam logic [ActW-1:0] ACT_LOAD = 2'd0;
  localparam logic [ActW-1:0] ACT_RUN  = 2'd1;
  localparam logic [ActW-1:0] ACT_READ = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ALPHA  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ITER   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_LEFT,
    OP_RIGHT,
    OP_UP,
    OP_DOWN
  } op_e;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_READ,
    OUT_DONE
  } out_e;

  typedef struct packed {
    logic ld_we;
    logic run_start;
    op_e  op;
    logic div_start;
    logic wr_en;
    logic wr_buf;
    logic wr_copy;
    logic buf_sel;
    logic out_load;
    out_e out_kind;
    logic rd_ok;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

/* design/gijr_if.sv */
// ----------------------------------------------------------------------------
// gijr_if: item channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gijr_in_if;
  import gijr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ActW-1:0]         action;
  logic [IdxW-1:0]         element_index;
  logic signed [DataW-1:0] primal;
  logic signed [DataW-1:0] grad_pos_x;
  logic signed [DataW-1:0] grad_neg_x;
  logic signed [DataW-1:0] grad_pos_y;
  logic signed [DataW-1:0] grad_neg_y;
  modport source (output valid, action, element_index, primal, grad_pos_x, grad_neg_x,
                  grad_pos_y, grad_neg_y, input ready);
  modport sink (input valid, action, element_index, primal, grad_pos_x, grad_neg_x,
                grad_pos_y, grad_neg_y, output ready);
endinterface

interface gijr_out_if;
  import gijr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    done_res;
  modport source (output valid, value, done_res, input ready);
  modport sink (input valid, value, done_res, output ready);
endinterface

/* design/gijr_div.sv */
// ----------------------------------------------------------------------------
// gijr_div: rounding divider
// Restoring divider, one quotient bit per cycle, round half away from zero,
// result saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module gijr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [gijr_pkg::NumW-1:0] num_i,
  input  logic [gijr_pkg::DenW-1:0]     den_i,
  output logic                          done_o,
  output logic signed [gijr_pkg::DataW-1:0] quot_o
);
  import gijr_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  logic            neg_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_sh;
  logic            fits;
  logic [NumW-1:0] mag;

  assign mag    = (num_i < 0) ? NumW'(-num_i) : NumW'(num_i);
  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign cnt_d  = cnt_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(NumW);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i < 0;
      quo_q <= mag + NumW'(den_i >> 1);
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? DenW'(rem_sh - {1'b0, den_q}) : DenW'(rem_sh);
    end
  end

  always_comb begin
    if (neg_q) begin
      if (quo_q >= NumW'(64'h8000_0000)) begin
        quot_o = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        quot_o = -$signed(quo_q[DataW-1:0]);
      end
    end else begin
      if (quo_q > NumW'(64'h7FFF_FFFF)) begin
        quot_o = {1'b0, {(DataW-1){1'b1}}};
      end else begin
        quot_o = $signed(quo_q[DataW-1:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

/* design/gijr_dpath.sv */
// ----------------------------------------------------------------------------
// gijr_dpath: element stores and stencil arithmetic
// Holds the primal, gradient and reconstruction memories, accumulates the
// stencil numerator and denominator and drives the result register.
// ----------------------------------------------------------------------------
module gijr_dpath #(
  parameter int MAX_WIDTH  = gijr_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = gijr_pkg::DefMaxHeight,
  parameter int CHANNELS   = gijr_pkg::DefChannels
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gijr_pkg::cmd_t                     cmd_i,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT*CHANNELS)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT*CHANNELS)-1:0] wr_addr_i,
  input  logic [gijr_pkg::IdxW-1:0]          element_index_i,
  input  logic signed [gijr_pkg::DataW-1:0]  primal_i,
  input  logic signed [gijr_pkg::DataW-1:0]  grad_pos_x_i,
  input  logic signed [gijr_pkg::DataW-1:0]  grad_neg_x_i,
  input  logic signed [gijr_pkg::DataW-1:0]  grad_pos_y_i,
  input  logic signed [gijr_pkg::DataW-1:0]  grad_neg_y_i,
  input  logic [gijr_pkg::AlphaW-1:0]        alpha_i,
  output gijr_pkg::status_t                  status_o,
  output logic signed [gijr_pkg::DataW-1:0]  value_o,
  output logic                               done_res_o
);
  import gijr_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int AW    = $clog2(Depth);

  logic signed [DataW-1:0] primal_mem [Depth];
  logic signed [DataW-1:0] pos_x_mem  [Depth];
  logic signed [DataW-1:0] neg_x_mem  [Depth];
  logic signed [DataW-1:0] pos_y_mem  [Depth];
  logic signed [DataW-1:0] neg_y_mem  [Depth];
  logic signed [DataW-1:0] buf_a_mem  [Depth];
  logic signed [DataW-1:0] buf_b_mem  [Depth];

  logic signed [DataW-1:0] primal_rd_q, pos_x_rd_q, neg_x_rd_q, pos_y_rd_q, neg_y_rd_q;
  logic signed [DataW-1:0] buf_a_rd_q, buf_b_rd_q, src_rd;

  logic [AW-1:0]           ld_addr;
  logic [AsqW-1:0]         asq_q;
  logic [2*AlphaW-1:0]     asq_full;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DataW-1:0] primal_p_q, pos_x_p_q, neg_x_p_q, pos_y_p_q, neg_y_p_q;
  logic signed [NumW-1:0]  acc_q;
  logic [DenW-1:0]         den_q;
  logic signed [DataW:0]   diff;
  logic signed [NumW-1:0]  term;
  logic signed [NumW-1:0]  num;
  logic signed [DataW-1:0] quot;
  logic signed [DataW-1:0] wr_data;
  logic                    div_done;

  assign ld_addr  = AW'(element_index_i);
  assign src_rd   = cmd_i.buf_sel ? buf_b_rd_q : buf_a_rd_q;
  assign asq_full = alpha_i * alpha_i + (2*AlphaW)'(128);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_we) begin
      primal_mem[ld_addr] <= primal_i;
      pos_x_mem[ld_addr]  <= grad_pos_x_i;
      neg_x_mem[ld_addr]  <= grad_neg_x_i;
      pos_y_mem[ld_addr]  <= grad_pos_y_i;
      neg_y_mem[ld_addr]  <= grad_neg_y_i;
    end
    primal_rd_q <= primal_mem[rd_addr_i];
    pos_x_rd_q  <= pos_x_mem[rd_addr_i];
    neg_x_rd_q  <= neg_x_mem[rd_addr_i];
    pos_y_rd_q  <= pos_y_mem[rd_addr_i];
    neg_y_rd_q  <= neg_y_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_buf) begin
      buf_a_mem[wr_addr_i] <= wr_data;
    end
    buf_a_rd_q <= buf_a_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_buf) begin
      buf_b_mem[wr_addr_i] <= wr_data;
    end
    buf_b_rd_q <= buf_b_mem[rd_addr_i];
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_LEFT:  diff = $signed({pos_x_rd_q[DataW-1], pos_x_rd_q})
                     - $signed({neg_x_p_q[DataW-1], neg_x_p_q});
      OP_RIGHT: diff = $signed({neg_x_rd_q[DataW-1], neg_x_rd_q})
                     - $signed({pos_x_p_q[DataW-1], pos_x_p_q});
      OP_UP:    diff = $signed({pos_y_rd_q[DataW-1], pos_y_rd_q})
                     - $signed({neg_y_p_q[DataW-1], neg_y_p_q});
      OP_DOWN:  diff = $signed({neg_y_rd_q[DataW-1], neg_y_rd_q})
                     - $signed({pos_y_p_q[DataW-1], pos_y_p_q});
      default:  diff = '0;
    endcase
  end

  assign term = (NumW'(diff) <<< UnitG) + (NumW'(src_rd) <<< UnitR);
  assign num  = acc_q + (NumW'(prod_q) <<< 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      asq_q <= asq_full[AsqW+7:8];
    end
    unique case (cmd_i.op)
      OP_INIT: begin
        prod_q     <= ProdW'(primal_rd_q * $signed({1'b0, asq_q}));
        primal_p_q <= primal_rd_q;
        pos_x_p_q  <= pos_x_rd_q;
        neg_x_p_q  <= neg_x_rd_q;
        pos_y_p_q  <= pos_y_rd_q;
        neg_y_p_q  <= neg_y_rd_q;
        acc_q      <= '0;
        den_q      <= DenW'({asq_q, 1'b0});
      end
      OP_LEFT, OP_RIGHT, OP_UP, OP_DOWN: begin
        acc_q <= acc_q + term;
        den_q <= den_q + (DenW'(1) << UnitR);
      end
      default: begin
      end
    endcase
  end

  gijr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    if (cmd_i.wr_copy) begin
      wr_data = primal_rd_q;
    end else if (den_q == '0) begin
      wr_data = primal_p_q;
    end else begin
      wr_data = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      value_o    <= (cmd_i.out_kind == OUT_READ && cmd_i.rd_ok) ? src_rd : '0;
      done_res_o <= cmd_i.out_kind == OUT_DONE;
    end
  end

  assign status_o.div_done = div_done;

endmodule

/* design/gijr_ctrl.sv */
// ----------------------------------------------------------------------------
// gijr_ctrl: sequencer
// Handles item handshakes and walks copy and sweep passes over the image.
// ----------------------------------------------------------------------------
module gijr_ctrl #(
  parameter int MAX_WIDTH  = gijr_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = gijr_pkg::DefMaxHeight,
  parameter int CHANNELS   = gijr_pkg::DefChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [gijr_pkg::ActW-1:0]     action_i,
  input  logic [gijr_pkg::IdxW-1:0]     element_index_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [gijr_pkg::IterW-1:0]    iteration_count_i,
  input  logic [gijr_pkg::DimW-1:0]     image_width_i,
  input  logic [gijr_pkg::DimW-1:0]     image_height_i,
  input  gijr_pkg::status_t             status_i,
  output gijr_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT*CHANNELS)-1:0] rd_addr_o,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT*CHANNELS)-1:0] wr_addr_o
);
  import gijr_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [2:0]       ph_q, ph_d;
  logic [AW-1:0]    p_q, p_d, row_q, row_d;
  logic [DimW-1:0]  x_q, x_d, y_q, y_d, w_q, w_d, h_q, h_d;
  logic [CW-1:0]    c_q, c_d;
  logic [IterW-1:0] it_q, it_d, it_inc;
  logic             sel_q, sel_d;
  logic             rd_ok_q, rd_ok_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire, idx_ok, last_elem, c_last, x_last, y_last;
  logic [DimW-1:0]  w_eff, h_eff;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign idx_ok      = 32'(element_index_i) < 32'(Depth);
  assign out_valid_o = out_valid_q;
  assign wr_addr_o   = p_q;
  assign it_inc      = it_q + IterW'(1);

  assign c_last    = c_q == CW'(CHANNELS - 1);
  assign x_last    = x_q == w_q - DimW'(1);
  assign y_last    = y_q == h_q - DimW'(1);
  assign last_elem = c_last && x_last && y_last;

  always_comb begin
    if (image_width_i == '0) begin
      w_eff = DimW'(1);
    end else if (32'(image_width_i) > MAX_WIDTH) begin
      w_eff = DimW'(MAX_WIDTH);
    end else begin
      w_eff = image_width_i;
    end
    if (image_height_i == '0) begin
      h_eff = DimW'(1);
    end else if (32'(image_height_i) > MAX_HEIGHT) begin
      h_eff = DimW'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    p_d         = p_q;
    x_d         = x_q;
    y_d         = y_q;
    c_d         = c_q;
    it_d        = it_q;
    w_d         = w_q;
    h_d         = h_q;
    row_d       = row_q;
    sel_d       = sel_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_addr_o   = p_q;
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.out_kind  = OUT_ZERO;
    cmd_o.rd_ok     = rd_ok_q;
    cmd_o.buf_sel   = (state_q == S_SWEEP || state_q == S_DIV) ? it_q[0] : sel_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (action_i)
            ACT_LOAD: begin
              cmd_o.ld_we    = idx_ok;
              cmd_o.out_load = 1'b1;
              out_valid_d    = 1'b1;
            end
            ACT_RUN: begin
              cmd_o.run_start = 1'b1;
              w_d     = w_eff;
              h_d     = h_eff;
              row_d   = AW'(w_eff * CHANNELS);
              p_d     = '0;
              x_d     = '0;
              y_d     = '0;
              c_d     = '0;
              it_d    = '0;
              ph_d    = '0;
              state_d = S_COPY;
            end
            ACT_READ: begin
              rd_addr_o = AW'(element_index_i);
              rd_ok_d   = idx_ok;
              state_d   = S_READ;
            end
            default: begin
              cmd_o.out_load = 1'b1;
              out_valid_d    = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = OUT_READ;
        out_valid_d    = 1'b1;
        state_d        = S_IDLE;
      end
      S_COPY: begin
        if (ph_q == '0) begin
          ph_d = 3'd1;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_copy = 1'b1;
          ph_d          = '0;
        end
      end
      S_SWEEP: begin
        ph_d = ph_q + 3'd1;
        unique case (ph_q)
          3'd0: rd_addr_o = p_q;
          3'd1: begin
            rd_addr_o = p_q - AW'(CHANNELS);
            cmd_o.op  = OP_INIT;
          end
          3'd2: begin
            rd_addr_o = p_q + AW'(CHANNELS);
            cmd_o.op  = (x_q != '0) ? OP_LEFT : OP_NONE;
          end
          3'd3: begin
            rd_addr_o = p_q - row_q;
            cmd_o.op  = !x_last ? OP_RIGHT : OP_NONE;
          end
          3'd4: begin
            rd_addr_o = p_q + row_q;
            cmd_o.op  = (y_q != '0) ? OP_UP : OP_NONE;
          end
          3'd5: cmd_o.op = !y_last ? OP_DOWN : OP_NONE;
          default: begin
            cmd_o.div_start = 1'b1;
            ph_d            = '0;
            state_d         = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_buf = ~it_q[0];
        end
      end
      default: state_d = S_IDLE;
    endcase

    // element advance after each write of a copy or sweep pass
    if (cmd_o.wr_en) begin
      if (!last_elem) begin
        p_d = p_q + AW'(1);
        if (c_last) begin
          c_d = '0;
          if (x_last) begin
            x_d = '0;
            y_d = y_q + DimW'(1);
          end else begin
            x_d = x_q + DimW'(1);
          end
        end else begin
          c_d = c_q + CW'(1);
        end
        if (state_q == S_DIV) begin
          state_d = S_SWEEP;
        end
      end else begin
        p_d = '0;
        x_d = '0;
        y_d = '0;
        c_d = '0;
        if (state_q == S_COPY) begin
          it_d = '0;
        end else begin
          it_d = it_inc;
        end
        if ((state_q == S_COPY && iteration_count_i == '0) ||
            (state_q == S_DIV && it_inc == iteration_count_i)) begin
          sel_d          = iteration_count_i[0];
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_DONE;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end else begin
          ph_d    = '0;
          state_d = S_SWEEP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= '0;
      p_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      c_q         <= '0;
      it_q        <= '0;
      w_q         <= DimW'(1);
      h_q         <= DimW'(1);
      row_q       <= '0;
      sel_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      p_q         <= p_d;
      x_q         <= x_d;
      y_q         <= y_d;
      c_q         <= c_d;
      it_q        <= it_d;
      w_q         <= w_d;
      h_q         <= h_d;
      row_q       <= row_d;
      sel_q       <= sel_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/gradient_image_jacobi_reconstruct_unit.sv */
// ----------------------------------------------------------------------------
// gradient_image_jacobi_reconstruct_unit: screened Poisson reconstruction
// Loads primal values and one-sided gradients, runs Jacobi sweeps, reads back.
// ----------------------------------------------------------------------------
// A load item, a read item or an unknown action each returns one result item. A
// run item copies the primal image, then runs iteration_count Jacobi sweeps
// over N elements (width*height*CHANNELS), each element of each sweep using
// the 64-step restoring divider. The run's result carries done_res = 1.
module gradient_image_jacobi_reconstruct_unit #(
  parameter int MAX_WIDTH  = gijr_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = gijr_pkg::DefMaxHeight,
  parameter int CHANNELS   = gijr_pkg::DefChannels
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gijr_in_if.sink                      in_i,
  gijr_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [gijr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gijr_pkg::AlphaW-1:0]  cfg_data_i
);
  import gijr_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT * CHANNELS);

  logic [AlphaW-1:0] alpha_q;
  logic [IterW-1:0]  iter_q;
  logic [DimW-1:0]   width_q, height_q;
  cmd_t              cmd;
  status_t           status;
  logic [AW-1:0]     rd_addr, wr_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= AlphaRst;
      iter_q   <= IterRst;
      width_q  <= DimRst;
      height_q <= DimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA:  alpha_q  <= cfg_data_i;
        CFG_ITER:   iter_q   <= cfg_data_i[IterW-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        default: begin
        end
      endcase
    end
  end

  gijr_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_i.valid),
    .action_i          (in_i.action),
    .element_index_i   (in_i.element_index),
    .in_ready_o        (in_i.ready),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .iteration_count_i (iter_q),
    .image_width_i     (width_q),
    .image_height_i    (height_q),
    .status_i          (status),
    .cmd_o             (cmd),
    .rd_addr_o         (rd_addr),
    .wr_addr_o         (wr_addr)
  );

  gijr_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .wr_addr_i       (wr_addr),
    .element_index_i (in_i.element_index),
    .primal_i        (in_i.primal),
    .grad_pos_x_i    (in_i.grad_pos_x),
    .grad_neg_x_i    (in_i.grad_neg_x),
    .grad_pos_y_i    (in_i.grad_pos_y),
    .grad_neg_y_i    (in_i.grad_neg_y),
    .alpha_i         (alpha_q),
    .status_o        (status),
    .value_o         (out_o.value),
    .done_res_o      (out_o.done_res)
  );

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_res |-> out_o.value == '0)
    else $error("done result carries a nonzero value");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.action == ACT_RUN |=> !in_i.ready)
    else $error("item accepted right after a run started");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.action == ACT_LOAD |=> out_o.valid)
    else $error("load item gave no result");

endmodule
